// ===== hw/rtl/bti_pkg.sv =====
// bti_pkg: shared types and constants of the bilinear table interpolator.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps
package bti_pkg;

   localparam int VAL_W = 32;

   typedef enum logic [1:0] {
      OP_WR_FIRST  = 2'd0,
      OP_WR_SECOND = 2'd1,
      OP_WR_GRID   = 2'd2,
      OP_QUERY     = 2'd3
   } opcode_type;

   localparam logic [1:0] ST_IN_RANGE = 2'd0;
   localparam logic [1:0] ST_BELOW    = 2'd1;
   localparam logic [1:0] ST_ABOVE    = 2'd2;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_ZERO = 2'd1;
   localparam logic [1:0] ERR_SAT  = 2'd2;

   localparam logic REG_FIRST_POINTS  = 1'b0;
   localparam logic REG_SECOND_POINTS = 1'b1;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [VAL_W-1:0] lo;
      logic signed [VAL_W-1:0] hi;
   } axis_res_type;

   typedef enum logic [2:0] {
      L_IDLE, L_MUL_A, L_MUL_B, L_SUM, L_CHK, L_DIV, L_FIN
   } lerp_state_type;

   typedef enum logic [2:0] {
      T_IDLE, T_SEARCH, T_GRID, T_LERP1, T_LERP2, T_LERP3, T_DONE
   } top_state_type;

endpackage

// ===== hw/rtl/bti_axis.sv =====
// bti_axis: breakpoint memory of one axis and the sequential segment search.
// Depends on bti_pkg.
`timescale 1ns / 1ps
module bti_axis import bti_pkg::*; #(
   parameter int MAX_POINTS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [$clog2(MAX_POINTS)-1:0]     wr_addr,
   input  logic signed [VAL_W-1:0]           wr_data,
   input  logic                              start,
   input  logic signed [VAL_W-1:0]           x,
   input  logic [$clog2(MAX_POINTS+1)-1:0]   n,
   output logic                              done,
   output logic [$clog2(MAX_POINTS)-1:0]     seg,
   output axis_res_type                      result
);
   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS+1);

   logic signed [VAL_W-1:0] mem [MAX_POINTS];
   logic signed [VAL_W-1:0] rd_data_ff;
   logic [CW-1:0]           cnt_ff, rd_idx_ff;
   logic                    busy_ff, rd_vld_ff, fin_ff, hit_ff;
   logic [AW-1:0]           hseg_ff;
   logic signed [VAL_W-1:0] prev_ff, first_ff, last_ff;
   logic signed [VAL_W-1:0] hlo_ff, hhi_ff, p0lo_ff, p0hi_ff, pllo_ff, plhi_ff;
   logic                    in_seg;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (busy_ff) begin
         rd_data_ff <= mem[cnt_ff[AW-1:0]];
      end
   end

   assign in_seg = (x >= prev_ff) && (x <= rd_data_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         rd_vld_ff <= 1'b0;
         fin_ff    <= 1'b0;
         hit_ff    <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         rd_vld_ff <= busy_ff;
         rd_idx_ff <= cnt_ff;
         fin_ff    <= rd_vld_ff && (rd_idx_ff == n - CW'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            hit_ff  <= 1'b0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == n - CW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
         if (rd_vld_ff && rd_idx_ff != '0 && in_seg && !hit_ff) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // Pair (prev, current) forms segment rd_idx-1.
   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         prev_ff <= rd_data_ff;
         if (rd_idx_ff == '0) begin
            first_ff <= rd_data_ff;
         end else begin
            if (in_seg && !hit_ff) begin
               hseg_ff <= AW'(rd_idx_ff - CW'(1));
               hlo_ff  <= prev_ff;
               hhi_ff  <= rd_data_ff;
            end
            if (rd_idx_ff == CW'(1)) begin
               p0lo_ff <= prev_ff;
               p0hi_ff <= rd_data_ff;
            end
            if (rd_idx_ff == n - CW'(1)) begin
               pllo_ff <= prev_ff;
               plhi_ff <= rd_data_ff;
               last_ff <= rd_data_ff;
            end
         end
      end
   end

   assign done = fin_ff;

   always_comb begin
      if (hit_ff) begin
         seg    = hseg_ff;
         result = '{status: ST_IN_RANGE, lo: hlo_ff, hi: hhi_ff};
      end else if (x < first_ff) begin
         seg    = '0;
         result = '{status: ST_BELOW, lo: p0lo_ff, hi: p0hi_ff};
      end else if (x > last_ff) begin
         seg    = AW'(n - CW'(2));
         result = '{status: ST_ABOVE, lo: pllo_ff, hi: plhi_ff};
      end else begin
         seg    = '0;
         result = '{status: ST_IN_RANGE, lo: p0lo_ff, hi: p0hi_ff};
      end
   end

endmodule

// ===== hw/rtl/bti_lerp.sv =====
// bti_lerp: one linear step (va*(hi-x)+vb*(x-lo))/(hi-lo), the two products formed
// in turn and a one-bit-per-cycle restoring divider. Depends on bti_pkg.
`timescale 1ns / 1ps
module bti_lerp import bti_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [VAL_W-1:0] va,
   input  logic signed [VAL_W-1:0] vb,
   input  logic signed [VAL_W-1:0] lo,
   input  logic signed [VAL_W-1:0] hi,
   input  logic signed [VAL_W-1:0] x,
   output logic                    done,
   output logic signed [VAL_W-1:0] result,
   output logic                    sat
);
   localparam int W  = VAL_W;
   localparam int DW = W + 1;
   localparam int PW = 2 * W + 1;
   localparam int NW = 2 * DW;
   localparam int KW = $clog2(DW);
   localparam logic [DW-1:0] POS_MAX = DW'((64'd1 << (W - 1)) - 64'd1);
   localparam logic [DW-1:0] NEG_MAG = DW'(64'd1 << (W - 1));
   localparam logic [W-1:0]  RES_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  RES_MIN = {1'b1, {(W-1){1'b0}}};

   lerp_state_type state_ff, state_in;

   logic signed [W-1:0]  va_ff, vb_ff;
   logic signed [DW-1:0] da_ff, db_ff, w_s;
   logic [DW-1:0]        d_ff;
   logic                 wneg_ff, neg_ff, over_ff;
   logic signed [PW-1:0] pa_ff, pb_ff;
   logic signed [NW-1:0] num;
   logic [NW-1:0]        mag_ff;
   logic [DW-1:0]        rem_ff, low_ff;
   logic [DW:0]          rem2, diff;
   logic                 ge;
   logic [KW-1:0]        k_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         L_IDLE:  if (start) state_in = L_MUL_A;
         L_MUL_A: state_in = L_MUL_B;
         L_MUL_B: state_in = L_SUM;
         L_SUM:   state_in = L_CHK;
         L_CHK:   state_in = L_DIV;
         L_DIV:   if (k_ff == KW'(DW - 1)) state_in = L_FIN;
         L_FIN:   state_in = L_IDLE;
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign w_s  = {hi[W-1], hi} - {lo[W-1], lo};
   assign num  = {pa_ff[PW-1], pa_ff} + {pb_ff[PW-1], pb_ff};
   assign rem2 = {rem_ff, low_ff[DW-1]};
   assign diff = rem2 - {1'b0, d_ff};
   assign ge   = rem2 >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      case (state_ff)
         L_IDLE: begin
            va_ff   <= va;
            vb_ff   <= vb;
            da_ff   <= {hi[W-1], hi} - {x[W-1], x};
            db_ff   <= {x[W-1], x} - {lo[W-1], lo};
            wneg_ff <= w_s[DW-1];
            d_ff    <= w_s[DW-1] ? DW'(-w_s) : DW'(w_s);
         end
         L_MUL_A: pa_ff <= va_ff * da_ff;
         L_MUL_B: pb_ff <= vb_ff * db_ff;
         L_SUM: begin
            neg_ff <= num[NW-1] != wneg_ff;
            mag_ff <= num[NW-1] ? NW'(-num) : NW'(num);
         end
         L_CHK: begin
            // quotient of 2^DW or more saturates regardless of sign
            over_ff <= mag_ff >= {d_ff, {DW{1'b0}}};
            rem_ff  <= mag_ff[NW-1:DW];
            low_ff  <= mag_ff[DW-1:0];
            k_ff    <= '0;
         end
         L_DIV: begin
            rem_ff <= ge ? diff[DW-1:0] : rem2[DW-1:0];
            low_ff <= {low_ff[DW-2:0], ge};
            k_ff   <= k_ff + KW'(1);
         end
         default: ;
      endcase
   end

   always_comb begin
      done   = (state_ff == L_FIN);
      sat    = 1'b0;
      result = '0;
      if (done) begin
         if (over_ff) begin
            sat    = 1'b1;
            result = neg_ff ? RES_MIN : RES_MAX;
         end else if (neg_ff) begin
            if (low_ff > NEG_MAG) begin
               sat    = 1'b1;
               result = RES_MIN;
            end else begin
               result = W'(-low_ff);
            end
         end else if (low_ff > POS_MAX) begin
            sat    = 1'b1;
            result = RES_MAX;
         end else begin
            result = low_ff[W-1:0];
         end
      end
   end

endmodule

// ===== hw/rtl/bilinear_table_interpolator.sv =====
// bilinear_table_interpolator: top level, grid memory, sequencing, output stage.
// Depends on bti_pkg, bti_axis, bti_lerp.
`timescale 1ns / 1ps
// Two-dimensional lookup table with bilinear interpolation in signed Q16.16.
// Items write a first-axis breakpoint, a second-axis breakpoint or a grid
// value (no result), or ask a query that returns one result. In a query
// the two axis searches run side by side reading one breakpoint a cycle
// from their memories; unless a segment has zero width, four grid reads
// follow, then three linear steps on one shared unit, each dominated by
// its bit-serial divide.
// One item is worked on at a time; a new item is taken while the last result
// still waits in the output register. Point counts are written over the
// register port and are clamped to 2..MAX_AXIS_POINTS; the user must write
// them only while the block is idle, which the block does not enforce.
// Stores hold no defined value until written; queries must touch only
// written entries.
module bilinear_table_interpolator import bti_pkg::*; #(
   parameter int MAX_AXIS_POINTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [7:0] entry_index, [39:8] entry_value, [71:40] query_first,
   // [103:72] query_second
   input  logic [103:0] req_tdata,
   // [1:0] opcode
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] interpolated_value
   output logic [31:0]  rsp_tdata,
   // [1:0] first_axis_status, [3:2] second_axis_status, [5:4] arithmetic_error
   output logic [5:0]   rsp_tuser,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   localparam int AW     = $clog2(MAX_AXIS_POINTS);
   localparam int CW     = $clog2(MAX_AXIS_POINTS + 1);
   localparam int GRID_D = MAX_AXIS_POINTS * MAX_AXIS_POINTS;
   localparam int GAW    = $clog2(GRID_D);

   // ---- input item fields
   opcode_type              op;
   logic [7:0]              idx;
   logic signed [VAL_W-1:0] val, qx1, qx2;
   logic                    req_acc, query_go;

   assign op       = opcode_type'(req_tuser);
   assign idx      = req_tdata[7:0];
   assign val      = req_tdata[39:8];
   assign qx1      = req_tdata[71:40];
   assign qx2      = req_tdata[103:72];
   assign req_acc  = req_tvalid && req_tready;
   assign query_go = req_acc && (op == OP_QUERY);

   // ---- configuration
   logic [CW-1:0] n1_ff, n2_ff, clamp_n;
   logic [7:0]    wv;

   assign pready = 1'b1;
   assign wv     = {3'b000, pwdata[4:0]};

   always_comb begin
      if (wv < 8'd2) begin
         clamp_n = CW'(2);
      end else if (wv > 8'(MAX_AXIS_POINTS)) begin
         clamp_n = CW'(MAX_AXIS_POINTS);
      end else begin
         clamp_n = CW'(wv);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_ff <= CW'(2);
         n2_ff <= CW'(2);
      end else if (psel && penable && pwrite && pready) begin
         unique case (paddr[2])
            REG_FIRST_POINTS:  n1_ff <= clamp_n;
            REG_SECOND_POINTS: n2_ff <= clamp_n;
            default: ;
         endcase
      end
   end

   assign prdata = (paddr[2] == REG_SECOND_POINTS) ? 32'(n2_ff) : 32'(n1_ff);

   // ---- axis stores and searches
   logic                    x_wr_ok, ax1_done, ax2_done, ax1_seen_ff, ax2_seen_ff;
   logic [AW-1:0]           seg1, seg2;
   axis_res_type            res1, res2;
   logic signed [VAL_W-1:0] x1_ff, x2_ff;

   assign x_wr_ok = idx < 8'(MAX_AXIS_POINTS);

   bti_axis #(.MAX_POINTS(MAX_AXIS_POINTS)) u_axis1 (
      .clock, .reset,
      .wr_en   (req_acc && op == OP_WR_FIRST && x_wr_ok),
      .wr_addr (idx[AW-1:0]),
      .wr_data (val),
      .start   (query_go),
      .x       (x1_ff),
      .n       (n1_ff),
      .done    (ax1_done),
      .seg     (seg1),
      .result  (res1)
   );

   bti_axis #(.MAX_POINTS(MAX_AXIS_POINTS)) u_axis2 (
      .clock, .reset,
      .wr_en   (req_acc && op == OP_WR_SECOND && x_wr_ok),
      .wr_addr (idx[AW-1:0]),
      .wr_data (val),
      .start   (query_go),
      .x       (x2_ff),
      .n       (n2_ff),
      .done    (ax2_done),
      .seg     (seg2),
      .result  (res2)
   );

   // ---- sequencer
   top_state_type state_ff, state_in;
   logic          zero_w, lerp_done, lerp_sat, both_seen, grid_last;
   logic [2:0]    g_cnt_ff;
   logic          g_vld_ff;
   logic [1:0]    g_idx_ff;

   assign both_seen = ax1_seen_ff && ax2_seen_ff;
   assign zero_w    = (res1.lo == res1.hi) || (res2.lo == res2.hi);
   assign grid_last = g_vld_ff && (g_idx_ff == 2'd3);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE:   if (query_go) state_in = T_SEARCH;
         T_SEARCH: if (both_seen) state_in = zero_w ? T_DONE : T_GRID;
         T_GRID:   if (grid_last) state_in = T_LERP1;
         T_LERP1:  if (lerp_done) state_in = T_LERP2;
         T_LERP2:  if (lerp_done) state_in = T_LERP3;
         T_LERP3:  if (lerp_done) state_in = T_DONE;
         T_DONE:   if (!rsp_tvalid || rsp_tready) state_in = T_IDLE;
         default:  state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      req_tready = (state_ff == T_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ax1_seen_ff <= 1'b0;
         ax2_seen_ff <= 1'b0;
      end else if (query_go) begin
         ax1_seen_ff <= 1'b0;
         ax2_seen_ff <= 1'b0;
      end else begin
         ax1_seen_ff <= ax1_seen_ff || ax1_done;
         ax2_seen_ff <= ax2_seen_ff || ax2_done;
      end
      if (query_go) begin
         x1_ff <= qx1;
         x2_ff <= qx2;
      end
   end

   // ---- grid memory: four corner reads, one per cycle
   logic signed [VAL_W-1:0] grid_mem [GRID_D];
   logic signed [VAL_W-1:0] g_rd_ff, g00_ff, g01_ff, g10_ff, g11_ff;
   logic [GAW-1:0]          r0_ff, g_addr;
   logic                    g_issue;

   assign g_issue = (state_ff == T_GRID) && (g_cnt_ff < 3'd4);
   assign g_addr  = r0_ff + (g_cnt_ff[1] ? GAW'(n2_ff) : GAW'(0))
                    + GAW'(seg2) + GAW'(g_cnt_ff[0]);

   always_ff @(posedge clock) begin
      if (req_acc && op == OP_WR_GRID && 32'(idx) < 32'(GRID_D)) begin
         grid_mem[GAW'(idx)] <= val;
      end
      if (g_issue) begin
         g_rd_ff <= grid_mem[g_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_cnt_ff <= '0;
         g_vld_ff <= 1'b0;
      end else begin
         g_vld_ff <= g_issue;
         g_idx_ff <= g_cnt_ff[1:0];
         if (state_ff == T_SEARCH) begin
            g_cnt_ff <= '0;
         end else if (g_issue) begin
            g_cnt_ff <= g_cnt_ff + 3'd1;
         end
      end
      if (state_ff == T_SEARCH) begin
         r0_ff <= GAW'({{CW{1'b0}}, seg1} * {{AW{1'b0}}, n2_ff});
      end
      if (g_vld_ff) begin
         case (g_idx_ff)
            2'd0: g00_ff <= g_rd_ff;
            2'd1: g01_ff <= g_rd_ff;
            2'd2: g10_ff <= g_rd_ff;
            default: g11_ff <= g_rd_ff;
         endcase
      end
   end

   // ---- linear steps: two along the second axis, one along the first
   logic                    lerp_go_ff;
   logic signed [VAL_W-1:0] l_va, l_vb, l_lo, l_hi, l_x, lerp_res;
   logic signed [VAL_W-1:0] v1_ff, v2_ff, fin_ff;
   logic                    sat_ff, zero_ff;

   always_comb begin
      l_va = g00_ff;
      l_vb = g01_ff;
      l_lo = res2.lo;
      l_hi = res2.hi;
      l_x  = x2_ff;
      case (state_ff)
         T_LERP2: begin
            l_va = g10_ff;
            l_vb = g11_ff;
         end
         T_LERP3: begin
            l_va = v1_ff;
            l_vb = v2_ff;
            l_lo = res1.lo;
            l_hi = res1.hi;
            l_x  = x1_ff;
         end
         default: ;
      endcase
   end

   bti_lerp u_lerp (
      .clock, .reset,
      .start  (lerp_go_ff),
      .va     (l_va),
      .vb     (l_vb),
      .lo     (l_lo),
      .hi     (l_hi),
      .x      (l_x),
      .done   (lerp_done),
      .result (lerp_res),
      .sat    (lerp_sat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lerp_go_ff <= 1'b0;
      end else begin
         lerp_go_ff <= (state_ff != state_in) &&
                       (state_in == T_LERP1 || state_in == T_LERP2 ||
                        state_in == T_LERP3);
      end
      if (query_go) begin
         sat_ff <= 1'b0;
      end else if (lerp_done) begin
         sat_ff <= sat_ff || lerp_sat;
      end
      if (state_ff == T_SEARCH) begin
         zero_ff <= zero_w;
      end
      if (lerp_done) begin
         case (state_ff)
            T_LERP1: v1_ff  <= lerp_res;
            T_LERP2: v2_ff  <= lerp_res;
            default: fin_ff <= lerp_res;
         endcase
      end
   end

   // ---- output register
   logic        rsp_vld_ff;
   logic [31:0] rsp_data_ff;
   logic [5:0]  rsp_user_ff;
   logic        rsp_load;

   assign rsp_load = (state_ff == T_DONE) && (!rsp_vld_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff <= zero_ff ? 32'd0 : fin_ff;
         rsp_user_ff <= {zero_ff ? ERR_ZERO : (sat_ff ? ERR_SAT : ERR_NONE),
                         res2.status, res1.status};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== hw/rtl/bti_checker.sv =====
// bti_checker: port-level assertions for the interpolator, bound to the top.
// Depends on bti_pkg and bilinear_table_interpolator.
`timescale 1ns / 1ps
module bti_checker import bti_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [5:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                     && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   a_zero_val: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[5:4] == ERR_ZERO |-> rsp_tdata == 32'd0)
      else $error("zero-width segment result not zero");

   a_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[1:0] != 2'd3 && rsp_tuser[3:2] != 2'd3
                     && rsp_tuser[5:4] != 2'd3)
      else $error("undefined status or error code");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind bilinear_table_interpolator bti_checker u_bti_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
);

// ===== bench/tb_bilinear_table_interpolator.sv =====
// tb_bilinear_table_interpolator: self-checking bench for the bilinear table interpolator.
// Depends on bti_pkg and bilinear_table_interpolator; needs no files or arguments.
`timescale 1ns / 1ps
module tb_bilinear_table_interpolator;
   import bti_pkg::*;

   typedef struct {
      logic [31:0] value;
      logic [1:0]  first_st;
      logic [1:0]  second_st;
      logic [1:0]  err;
   } lookup_result_type;

   // register byte addresses
   localparam logic [2:0] ADDR_FIRST_POINTS  = {REG_FIRST_POINTS, 2'b00};
   localparam logic [2:0] ADDR_SECOND_POINTS = {REG_SECOND_POINTS, 2'b00};
   localparam int DRAIN_CYCLES = 200;   // longer than one query

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // [7:0] entry_index, [39:8] entry_value, [71:40] query_first,
   // [103:72] query_second
   logic [103:0] req_tdata;
   // [1:0] opcode
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // [31:0] interpolated_value
   logic [31:0]  rsp_tdata;
   // [1:0] first_axis_status, [3:2] second_axis_status, [5:4] arithmetic_error
   logic [5:0]   rsp_tuser;
   logic         psel;
   logic         penable;
   logic         pwrite;
   logic [2:0]   paddr;
   logic [31:0]  pwdata;
   logic [31:0]  prdata;
   logic         pready;

   // mirror of the table contents and point counts
   logic signed [31:0] first_axis_mirror [16];
   logic signed [31:0] second_axis_mirror [16];
   logic signed [31:0] grid_mirror [256];
   int unsigned        first_points;
   int unsigned        second_points;

   lookup_result_type  pending_lookups [$];
   int                 fail_count;
   int                 idle_pct;

   bilinear_table_interpolator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   initial begin
      #12ms;
      $display("[bilinear_table_interpolator] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic int unsigned clamp_points(logic [4:0] raw);
      if (raw < 2) return 2;
      if (raw > 16) return 16;
      return raw;
   endfunction

   // first segment holding x; below/above pick an end segment
   function automatic int unsigned choose_segment(input logic signed [31:0] pts [16],
                                                  input int unsigned n,
                                                  input logic signed [31:0] x,
                                                  output logic [1:0] st);
      st = ST_IN_RANGE;
      for (int i = 0; i + 1 < n; i++)
         if (x >= pts[i] && x <= pts[i+1]) return i;
      if (x < pts[0]) begin
         st = ST_BELOW;
         return 0;
      end
      if (x > pts[n-1]) begin
         st = ST_ABOVE;
         return n - 2;
      end
      return 0;
   endfunction

   // (va*(hi-x) + vb*(x-lo)) / (hi-lo), truncated and saturated to 32 bits
   function automatic logic signed [31:0] blend_step(input logic signed [31:0] va,
                                                     input logic signed [31:0] vb,
                                                     input logic signed [31:0] lo,
                                                     input logic signed [31:0] hi,
                                                     input logic signed [31:0] x,
                                                     inout logic sat);
      logic signed [127:0] wa, wb, wlo, whi, wx, num, quot;
      wa = va; wb = vb; wlo = lo; whi = hi; wx = x;
      num = wa * (whi - wx) + wb * (wx - wlo);
      quot = num / (whi - wlo);
      if (quot > 128'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7FFFFFFF;
      end
      if (quot < -128'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return quot[31:0];
   endfunction

   function automatic lookup_result_type predict_lookup(logic signed [31:0] x1,
                                                        logic signed [31:0] x2);
      lookup_result_type r;
      int unsigned i1, j2, r0, r1;
      logic sat;
      logic signed [31:0] v1, v2;
      sat = 1'b0;
      r.value = '0;
      r.err = ERR_NONE;
      i1 = choose_segment(first_axis_mirror, first_points, x1, r.first_st);
      j2 = choose_segment(second_axis_mirror, second_points, x2, r.second_st);
      if (first_axis_mirror[i1] == first_axis_mirror[i1+1] ||
          second_axis_mirror[j2] == second_axis_mirror[j2+1]) begin
         r.err = ERR_ZERO;
      end else begin
         r0 = i1 * second_points;
         r1 = (i1 + 1) * second_points;
         v1 = blend_step(grid_mirror[r0+j2], grid_mirror[r0+j2+1],
                         second_axis_mirror[j2], second_axis_mirror[j2+1], x2, sat);
         v2 = blend_step(grid_mirror[r1+j2], grid_mirror[r1+j2+1],
                         second_axis_mirror[j2], second_axis_mirror[j2+1], x2, sat);
         r.value = blend_step(v1, v2, first_axis_mirror[i1], first_axis_mirror[i1+1],
                              x1, sat);
         if (sat) r.err = ERR_SAT;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // one item; mirror updated and result predicted at the accepting edge
   task automatic send_item(opcode_type op, logic [7:0] idx, logic [31:0] val,
                            logic [31:0] q1, logic [31:0] q2);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {q2, q1, val, idx};
      do @(posedge clock); while (!req_tready);
      case (op)
         OP_WR_FIRST:  if (idx < 16) first_axis_mirror[idx] = val;
         OP_WR_SECOND: if (idx < 16) second_axis_mirror[idx] = val;
         OP_WR_GRID:   grid_mirror[idx] = val;
         OP_QUERY:     pending_lookups.insert(pending_lookups.size(),
                                              predict_lookup(q1, q2));
      endcase
   endtask

   task automatic write_entry(opcode_type op, logic [7:0] idx, logic [31:0] val);
      send_item(op, idx, val, $urandom, $urandom);
   endtask

   task automatic ask(logic [31:0] q1, logic [31:0] q2);
      send_item(OP_QUERY, 8'($urandom), $urandom, q1, q2);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_points(logic [4:0] n1, logic [4:0] n2);
      wait_idle();
      csr_write(ADDR_FIRST_POINTS, {$urandom} & 32'hFFFF_FFE0 | n1);
      first_points = clamp_points(n1);
      csr_write(ADDR_SECOND_POINTS, n2);
      second_points = clamp_points(n2);
   endtask

   // breakpoints by style: 0 ascending fine, 1 ascending coarse,
   // 2 arbitrary, 3 ascending with repeats
   function automatic logic [31:0] next_point(int style, logic [31:0] prev, int i);
      case (style)
         0: return i == 0 ? $urandom_range(0, 32'h40000) - 32'h20000
                          : prev + $urandom_range(1, 32'h30000);
         1: return i == 0 ? 32'h9000_0000 + $urandom_range(0, 32'h0FFF_FFFF)
                          : prev + $urandom_range(1, 32'h0700_0000);
         2: return $urandom;
         default: return i == 0 ? $urandom_range(0, 32'h10000)
                                : prev + ($urandom_range(3) == 0 ? 0
                                          : $urandom_range(1, 32'h20000));
      endcase
   endfunction

   function automatic logic [31:0] grid_value(bit wide);
      if (wide || $urandom_range(9) == 0) return $urandom;
      return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
   endfunction

   task automatic load_table(int style, bit wide);
      logic [31:0] p;
      p = '0;
      for (int i = 0; i < first_points; i++) begin
         p = next_point(style, p, i);
         write_entry(OP_WR_FIRST, 8'(i), p);
      end
      p = '0;
      for (int i = 0; i < second_points; i++) begin
         p = next_point(style, p, i);
         write_entry(OP_WR_SECOND, 8'(i), p);
      end
      for (int r = 0; r < first_points; r++)
         for (int c = 0; c < second_points; c++)
            write_entry(OP_WR_GRID, 8'(r * second_points + c), grid_value(wide));
   endtask

   // coordinate mostly near the breakpoints, sometimes anywhere
   function automatic logic [31:0] pick_coord(bit second);
      int unsigned n;
      logic signed [31:0] p;
      n = second ? second_points : first_points;
      p = second ? second_axis_mirror[$urandom_range(n - 1)]
                 : first_axis_mirror[$urandom_range(n - 1)];
      case ($urandom_range(9))
         0: return $urandom;
         1, 2: return p;
         default: return p + $urandom_range(0, 32'h40000) - 32'h20000;
      endcase
   endfunction

   // mostly queries, with rewrites and ignored writes mixed in
   task automatic random_traffic(int count);
      int unsigned k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         if (k < 70)
            ask(pick_coord(0), pick_coord(1));
         else if (k < 80)
            write_entry(OP_WR_GRID, 8'($urandom_range(255)), grid_value(0));
         else if (k < 87)
            write_entry(OP_WR_FIRST, 8'($urandom_range(first_points - 1)),
                        next_point(0, first_axis_mirror[0], 0));
         else if (k < 94)
            write_entry(OP_WR_SECOND, 8'($urandom_range(second_points - 1)),
                        next_point(0, second_axis_mirror[0], 0));
         else
            write_entry($urandom_range(1) ? OP_WR_FIRST : OP_WR_SECOND,
                        8'($urandom_range(16, 255)), $urandom);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result checking and sink stalls
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      lookup_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_lookups.size() == 0) begin
            $error("unexpected result %h/%h", rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            e = pending_lookups.pop_front();
            if (rsp_tdata !== e.value) begin
               $error("interpolated_value exp %h got %h", e.value, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser[1:0] !== e.first_st) begin
               $error("first_axis_status exp %0d got %0d", e.first_st, rsp_tuser[1:0]);
               fail_count++;
            end
            if (rsp_tuser[3:2] !== e.second_st) begin
               $error("second_axis_status exp %0d got %0d", e.second_st, rsp_tuser[3:2]);
               fail_count++;
            end
            if (rsp_tuser[5:4] !== e.err) begin
               $error("arithmetic_error exp %0d got %0d", e.err, rsp_tuser[5:4]);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // 2x2 table: corners, both extrapolations, extreme coordinates,
   // saturation, ignored writes, zero-width and descending segments
   task automatic test_directed();
      set_points(5'd2, 5'd2);
      write_entry(OP_WR_FIRST, 8'd0, 32'h0000_0000);
      write_entry(OP_WR_FIRST, 8'd1, 32'h0001_0000);
      write_entry(OP_WR_SECOND, 8'd0, 32'h0000_0000);
      write_entry(OP_WR_SECOND, 8'd1, 32'h0002_0000);
      write_entry(OP_WR_GRID, 8'd0, 32'h0001_0000);
      write_entry(OP_WR_GRID, 8'd1, 32'h7FFF_FFFF);
      write_entry(OP_WR_GRID, 8'd2, 32'h8000_0000);
      write_entry(OP_WR_GRID, 8'd3, 32'h0004_0000);
      ask(32'h0000_0000, 32'h0000_0000);
      ask(32'h0000_8000, 32'h0001_0000);
      ask(32'hFFFF_0000, 32'h0003_0000);
      ask(32'h8000_0000, 32'h7FFF_FFFF);
      ask(32'h7FFF_FFFF, 32'h8000_0000);
      write_entry(OP_WR_FIRST, 8'd255, 32'hDEAD_BEEF);   // past the store
      write_entry(OP_WR_SECOND, 8'd16, 32'hFFFF_FFFF);
      ask(32'h0000_4000, 32'h0000_4000);
      write_entry(OP_WR_FIRST, 8'd1, 32'h0000_0000);     // zero width
      ask(32'h0000_0000, 32'h0001_0000);
      write_entry(OP_WR_FIRST, 8'd1, 32'hFFFF_0000);     // descending
      ask(32'hFFFF_8000, 32'h0000_8000);
      ask(32'h0000_8000, 32'hFFFF_8000);
   endtask

   task automatic test_phase(logic [4:0] n1, logic [4:0] n2, int style, bit wide,
                             int count);
      set_points(n1, n2);
      load_table(style, wide);
      random_traffic(count);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_WR_FIRST;
      psel       = 1'b0;
      penable    = 1'b0;
      pwrite     = 1'b0;
      paddr      = '0;
      pwdata     = '0;
      fail_count = 0;
      idle_pct   = 35;
      first_points  = 2;
      second_points = 2;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_phase(5'd16, 5'd16, 0, 0, 150);     // largest table
      test_phase(5'd0, 5'd31, 3, 0, 200);      // clamped to 2 x 16, repeats
      idle_pct = 0;                            // back-to-back stretch
      test_phase(5'd31, 5'd1, 1, 1, 200);      // clamped to 16 x 2, coarse
      idle_pct = 35;
      test_phase(5'd3, 5'd4, 2, 0, 100);       // arbitrary breakpoints
      test_phase(5'($urandom_range(2, 8)), 5'($urandom_range(2, 8)), 0, 1, 100);
      test_phase(5'd5, 5'd17, 3, 0, 150);

      wait_idle();
      if (fail_count == 0)
         $display("[bilinear_table_interpolator] OK");
      else
         $display("[bilinear_table_interpolator] ERROR");
      $finish;
   end

endmodule
